// ===== rtl/sis_pkg.sv =====
// Shared types and constants for the sorted insertion stack.
// No dependencies; every other file in the block imports this package.
package sis_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;
  localparam int CNT_W     = 5;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_POP_EMPTY = 2'd2
  } status_t;

  // Control broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic                    push;
    logic                    pop;
    logic signed [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

// ===== rtl/sis_if.sv =====
// Valid/ready stream interfaces for the input and result channels.
// Depends on sis_pkg for field widths.
interface sis_in_if import sis_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface sis_out_if import sis_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] top_value;
  logic                    top_valid;
  logic [CNT_W-1:0]        count;
  logic [1:0]              status;

  modport source (output valid, output top_value, output top_valid, output count,
                  output status, input ready);
  modport sink   (input valid, input top_value, input top_valid, input count,
                  input status, output ready);
endinterface

// ===== rtl/sis_cell.sv =====
// One slot of the sorted chain: holds a value and trades it with its neighbors.
// Depends on sis_pkg for the control struct and value width.
module sis_cell import sis_pkg::*; (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic                    occ,
  input  logic signed [VAL_W-1:0] above_val,
  input  logic                    above_lt,
  input  logic signed [VAL_W-1:0] below_val,
  output logic signed [VAL_W-1:0] val,
  output logic signed [VAL_W-1:0] val_nxt,
  output logic                    lt
);

  logic signed [VAL_W-1:0] val_r;

  // An occupied cell strictly below the new value stays where it is.
  assign lt  = occ && (val_r < ctl.value);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.push) begin
      if (lt) begin
        val_nxt = val_r;
      end else if (above_lt) begin
        val_nxt = ctl.value;
      end else begin
        val_nxt = above_val;
      end
    end else if (ctl.pop) begin
      val_nxt = below_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== rtl/sorted_insertion_stack.sv =====
// Sorted stack of signed values, smallest on top, built as a chain of cells.
// The result of an input transfer is loaded into the output register in the cycle after the transfer.
// Throughput: one push or pop per cycle while the result is not stalled; every cell compares and shifts in parallel.
// Reset: synchronous active-low rst_n empties the stack and clears the output valid.
// Cell contents are not reset; only slots below the count are ever shown.
module sorted_insertion_stack import sis_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sis_in_if.sink    in_if,
  sis_out_if.source out_if
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r;
  logic signed [VAL_W-1:0] top_value_r;
  logic          top_valid_r;
  logic [CNT_W-1:0] count_out_r;
  status_t       status_r, status_nxt;

  logic          xfer;
  cell_ctl_t     ctl;
  logic signed [VAL_W-1:0] cell_val [DEPTH];
  logic signed [VAL_W-1:0] cell_nxt [DEPTH];
  logic          cell_lt [DEPTH];
  logic [CW+CNT_W-1:0] count_ext;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign xfer        = in_if.valid && in_if.ready;

  always_comb begin
    ctl.value  = in_if.value;
    ctl.push   = 1'b0;
    ctl.pop    = 1'b0;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    if (xfer) begin
      if (in_if.opcode == OP_PUSH) begin
        if (count_r == FULL_CNT) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.push  = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end else begin
        if (count_r == '0) begin
          status_nxt = ST_POP_EMPTY;
        end else begin
          ctl.pop   = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    localparam logic [CW-1:0] KI = CW'(k);
    logic signed [VAL_W-1:0] above_val, below_val;
    logic above_lt;

    // Cell 0 is the top; a value entering it comes straight from the input.
    if (k == 0) begin : g_first
      assign above_val = ctl.value;
      assign above_lt  = 1'b0;
    end else begin : g_mid
      assign above_val = cell_val[k-1];
      assign above_lt  = cell_lt[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign below_val = cell_val[k];
    end else begin : g_up
      assign below_val = cell_val[k+1];
    end

    sis_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (KI < count_r),
      .above_val (above_val),
      .above_lt  (above_lt),
      .below_val (below_val),
      .val       (cell_val[k]),
      .val_nxt   (cell_nxt[k]),
      .lt        (cell_lt[k])
    );
  end

  assign count_ext = {{CNT_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      top_valid_r <= (count_nxt != '0);
      top_value_r <= (count_nxt != '0) ? cell_nxt[0] : '0;
      count_out_r <= count_ext[CNT_W-1:0];
      status_r    <= status_nxt;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.top_value = top_value_r;
  assign out_if.top_valid = top_valid_r;
  assign out_if.count     = count_out_r;
  assign out_if.status    = status_r;

endmodule

// ===== rtl/sis_checker.sv =====
// Port-level assertions for the sorted insertion stack, bound to the top level.
// Depends on sis_pkg for status codes and field widths.
module sis_checker import sis_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [VAL_W-1:0] top_value,
  input logic                    top_valid,
  input logic [CNT_W-1:0]        count,
  input logic [1:0]              status
);

  localparam logic [CNT_W-1:0] FULL_MOD = CNT_W'(DEPTH % 32);

  // Every input transfer leaves a result waiting in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after input transfer");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !top_valid |-> top_value == '0 && count == '0)
    else $error("empty stack reports nonzero top or count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_FULL |-> count == FULL_MOD && top_valid)
    else $error("full status with wrong count");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_POP_EMPTY |-> count == '0 && !top_valid)
    else $error("pop-on-empty status with stored values");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(top_value) && $stable(count))
    else $error("stalled result changed");

endmodule

bind sorted_insertion_stack sis_checker #(.DEPTH(DEPTH)) u_sis_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .top_value (out_if.top_value),
  .top_valid (out_if.top_valid),
  .count     (out_if.count),
  .status    (out_if.status)
);
